// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/gie_pkg.sv =====
// Package with constants and types of the gray image enhance pipeline.
package gie_pkg;
  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned XW = $clog2(MaxWidth);
  localparam int unsigned YW = $clog2(MaxHeight);
  localparam int unsigned AW = XW + YW;
  localparam int unsigned WW = XW + 1;
  localparam int unsigned HW = YW + 1;
  localparam int unsigned CW = AW + 1;

  typedef enum logic [2:0] {
    RegEnables = 3'd0, RegClip = 3'd1, RegGain = 3'd2,
    RegBinary = 3'd3, RegWidth = 3'd4, RegHeight = 3'd5
  } reg_idx_e;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdFetch = 1'b1;

  typedef struct packed {
    logic [3:0] enables;
    logic [7:0] clip;
    logic [7:0] gain;
    logic [7:0] binary;
    logic [WW-1:0] width;
    logic [HW-1:0] height;
  } cfg_t;
endpackage

// ===== rtl/gie_stream_if.sv =====
// Valid/ready channel interfaces for pixel commands, results and configuration.
interface gie_cmd_if;
  logic valid;
  logic ready;
  logic command;
  logic [7:0] pixel_in;
  modport source (output valid, command, pixel_in, input ready);
  modport sink (input valid, command, pixel_in, output ready);
endinterface

interface gie_res_if;
  logic valid;
  logic ready;
  logic [7:0] pixel_out;
  logic last_out;
  logic status;
  modport source (output valid, pixel_out, last_out, status, input ready);
  modport sink (input valid, pixel_out, last_out, status, output ready);
endinterface

interface gie_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [8:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/gray_image_enhance_pipeline.sv =====
// Top level of the gray image enhance pipeline.
// The block stores one grayscale frame in a single-port frame memory and returns
// processed pixels in raster order on fetch transactions. A write transaction is taken
// in the idle state and the next command can follow in the very next cycle; writes to a full
// frame are dropped. A fetch first splits the read index into column and line with the
// shared 17-step iterative divider, then reads the center pixel and up to four
// neighbors from the frame memory one at a time, each read followed by a pass through
// the same divider when the contrast stretch is on, and then forms the result. One
// command is worked on at a time. The result sits in an output register; while it
// waits, the next command transaction is taken and worked on, and only the forming of
// the following result stalls until the register is free. A fetch before the frame is
// loaded returns status 1 through the output register without reading the memory.
module gray_image_enhance_pipeline (
  input logic clk_i,
  input logic rst_ni,
  gie_cfg_if.sink    cfg_i,
  gie_cmd_if.sink    cmd_i,
  gie_res_if.source  res_o
);
  typedef enum logic [2:0] {
    StIdle, StPos, StPosWait, StRead, StWait, StDiv, StAcc, StOut
  } state_e;

  gie_pkg::cfg_t cfg_q;
  state_e state_q;
  logic [gie_pkg::CW-1:0] load_q;
  logic [gie_pkg::AW-1:0] rd_q;
  logic [7:0] min_q, max_q;
  logic [2:0] nb_q;        // neighbor index: 0 center, 1 left, 2 right, 3 up, 4 down
  logic signed [12:0] lap_q;
  logic [7:0] c_q;
  logic [7:0] p_q;
  logic        err_q;      // the fetch in flight came before the frame was loaded
  logic        rv_q;
  logic [7:0]  rpix_q;
  logic        rlast_q, rstat_q;

  // Effective frame size after saturation.
  logic [gie_pkg::WW-1:0] w;
  logic [gie_pkg::HW-1:0] h;
  logic [gie_pkg::CW-1:0] total;
  always_comb begin
    w = (cfg_q.width == '0) ? gie_pkg::WW'(1) :
        (cfg_q.width > gie_pkg::WW'(gie_pkg::MaxWidth)) ?
        gie_pkg::WW'(gie_pkg::MaxWidth) : cfg_q.width;
    h = (cfg_q.height == '0) ? gie_pkg::HW'(1) :
        (cfg_q.height > gie_pkg::HW'(gie_pkg::MaxHeight)) ?
        gie_pkg::HW'(gie_pkg::MaxHeight) : cfg_q.height;
    total = gie_pkg::CW'(w * h);
  end

  // Column and line of the current fetch, taken from the divider at the start of
  // every fetch of a loaded frame, so that they always follow the current frame width.
  logic [gie_pkg::WW-1:0] x_q;
  logic [gie_pkg::HW-1:0] y_q;

  logic [7:0] g;
  logic sharpen, stretch;
  assign g = (cfg_q.gain > 8'd128) ? 8'd128 : cfg_q.gain;
  assign sharpen = cfg_q.enables[2] && g != 8'd0 && w >= gie_pkg::WW'(3) &&
                   h >= gie_pkg::HW'(3);
  assign stretch = cfg_q.enables[1] && max_q > min_q;

  // Neighbor address.
  logic [gie_pkg::WW-1:0] nx;
  logic [gie_pkg::HW-1:0] ny;
  logic [gie_pkg::CW+1:0] naddr;
  always_comb begin
    nx = x_q; ny = y_q;
    case (nb_q)
      3'd1: nx = (x_q != '0) ? x_q - 1'b1 : '0;
      3'd2: nx = (x_q + 1'b1 < w) ? x_q + 1'b1 : w - 1'b1;
      3'd3: ny = (y_q != '0) ? y_q - 1'b1 : '0;
      3'd4: ny = (y_q + 1'b1 < h) ? y_q + 1'b1 : h - 1'b1;
      default: ;
    endcase
    naddr = (gie_pkg::CW+2)'(ny * w) + (gie_pkg::CW+2)'(nx);
  end

  // The output register is free when it is empty or its result leaves this cycle.
  logic cmd_fire, cfg_fire, res_free;
  assign cmd_i.ready = (state_q == StIdle);
  assign cfg_i.ready = 1'b1;
  assign cmd_fire = cmd_i.valid && cmd_i.ready;
  assign cfg_fire = cfg_i.valid;
  assign res_free = !rv_q || res_o.ready;

  logic [7:0] clip_pix;
  assign clip_pix = (cfg_q.enables[0] && cmd_i.pixel_in >= cfg_q.clip) ? 8'd255 :
                    cmd_i.pixel_in;

  logic we;
  logic [gie_pkg::AW-1:0] addr;
  logic [7:0] rdata;
  assign we = cmd_fire && cmd_i.command == gie_pkg::CmdWrite && load_q < total;
  assign addr = we ? load_q[gie_pkg::AW-1:0] : naddr[gie_pkg::AW-1:0];

  gie_ram #(.Width(8), .Depth(1 << gie_pkg::AW)) u_frame (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(clip_pix), .rdata_o(rdata)
  );

  // Stretch operand: saturated pixel minus the minimum, times 510, plus range, over twice the range.
  logic [7:0] ps, d8;
  logic [16:0] num;
  logic div_start, div_done;
  logic [7:0] quo;
  logic [8:0] rem;
  logic [16:0] div_num;
  logic [8:0] div_den;
  always_comb begin
    ps = (rdata < min_q) ? min_q : (rdata > max_q) ? max_q : rdata;
    d8 = max_q - min_q;
    num = 17'(ps - min_q) * 17'd510 + 17'(d8);
  end
  // The divider first splits the read index by the width, then serves the stretch.
  assign div_start = (state_q == StPos) || ((state_q == StWait) && stretch);
  assign div_num = (state_q == StPos) ? 17'(rd_q) : num;
  assign div_den = (state_q == StPos) ? w : {d8, 1'b0};
  gie_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .num_i(div_num),
    .den_i(div_den), .done_o(div_done), .quo_o(quo), .rem_o(rem)
  );

  // Final result from center and Laplacian.
  logic signed [21:0] s;
  logic signed [21:0] v;
  logic [7:0] vc, fin;
  always_comb begin
    s = 22'(signed'({1'b0, c_q})) * 22'sd64 + 22'(signed'({1'b0, g})) * 22'(lap_q);
    if (s >= 0) v = (s + 22'sd32) >>> 6;
    else v = -((-s + 22'sd32) >>> 6);
    if (!sharpen) vc = c_q;
    else if (v < 0) vc = 8'd0;
    else if (v > 22'sd255) vc = 8'd255;
    else vc = v[7:0];
    fin = cfg_q.enables[3] ? ((vc >= cfg_q.binary) ? 8'd255 : 8'd0) : vc;
  end

  logic last_fetch;
  assign last_fetch = (gie_pkg::CW'(rd_q) + 1'b1 == total);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{enables: 4'd0, clip: 8'd255, gain: 8'd0, binary: 8'd128,
                 width: gie_pkg::WW'(256), height: gie_pkg::HW'(256)};
      state_q <= StIdle;
      load_q <= '0; rd_q <= '0; min_q <= 8'd255; max_q <= 8'd0;
      nb_q <= '0; x_q <= '0; y_q <= '0; rv_q <= 1'b0;
      lap_q <= '0; c_q <= '0; p_q <= '0; err_q <= 1'b0;
      rpix_q <= '0; rlast_q <= 1'b0; rstat_q <= 1'b0;
    end else begin
      if (cfg_fire) begin
        case (cfg_i.index)
          gie_pkg::RegEnables: cfg_q.enables <= cfg_i.data[3:0];
          gie_pkg::RegClip:    cfg_q.clip    <= cfg_i.data[7:0];
          gie_pkg::RegGain:    cfg_q.gain    <= cfg_i.data[7:0];
          gie_pkg::RegBinary:  cfg_q.binary  <= cfg_i.data[7:0];
          gie_pkg::RegWidth:   cfg_q.width   <= cfg_i.data[gie_pkg::WW-1:0];
          gie_pkg::RegHeight:  cfg_q.height  <= cfg_i.data[gie_pkg::HW-1:0];
          default: ;
        endcase
      end
      if (state_q == StOut && res_free) rv_q <= 1'b1;
      else if (res_o.ready) rv_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (cmd_fire) begin
            if (cmd_i.command == gie_pkg::CmdWrite) begin
              if (we) begin
                load_q <= load_q + 1'b1;
                if (clip_pix < min_q) min_q <= clip_pix;
                if (clip_pix > max_q) max_q <= clip_pix;
              end
            end else if (load_q < total) begin
              err_q <= 1'b1;
              state_q <= StOut;
            end else begin
              // Read index saturates at the last pixel.
              if (gie_pkg::CW'(rd_q) >= total) begin
                rd_q <= gie_pkg::AW'(total - 1'b1);
              end
              err_q <= 1'b0;
              nb_q <= '0; lap_q <= '0;
              state_q <= StPos;
            end
          end
        end
        StPos: state_q <= StPosWait;
        StPosWait: if (div_done) begin
          x_q <= rem; y_q <= {1'b0, quo}; state_q <= StRead;
        end
        StRead: state_q <= StWait;
        StWait: begin
          p_q <= rdata;
          state_q <= stretch ? StDiv : StAcc;
        end
        StDiv: if (div_done) begin
          p_q <= quo; state_q <= StAcc;
        end
        StAcc: begin
          if (nb_q == 3'd0) begin
            c_q <= p_q;
            lap_q <= 13'(signed'({1'b0, p_q, 2'b00}));
          end else begin
            lap_q <= lap_q - 13'(signed'({1'b0, p_q}));
          end
          if (nb_q == 3'd4 || !sharpen) state_q <= StOut;
          else begin
            nb_q <= nb_q + 3'd1; state_q <= StRead;
          end
        end
        StOut: begin
          // Waits here while the previous result still occupies the output register.
          if (res_free) begin
            rpix_q <= err_q ? 8'd0 : fin;
            rlast_q <= !err_q && last_fetch;
            rstat_q <= err_q;
            if (!err_q) begin
              if (last_fetch) begin
                load_q <= '0; rd_q <= '0; min_q <= 8'd255; max_q <= 8'd0;
              end else begin
                rd_q <= rd_q + 1'b1;
              end
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign res_o.valid = rv_q;
  assign res_o.pixel_out = rpix_q;
  assign res_o.last_out = rlast_q;
  assign res_o.status = rstat_q;
endmodule

// ===== rtl/gie_ram.sv =====
// Generic single-port RAM with registered read.
module gie_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

// ===== rtl/gie_div.sv =====
// Radix-2 restoring divider computing (num) / (den) for the stretch and the fetch position.
module gie_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] num_i,
  input  logic [8:0]  den_i,
  output logic        done_o,
  output logic [7:0]  quo_o,
  output logic [8:0]  rem_o
);
  logic [16:0] q_q, q_d;
  logic [9:0]  r_q, r_d;
  logic [8:0]  den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [9:0]  trial;
  logic        done_d, done_q;

  always_comb begin
    q_d = q_q; r_d = r_q; den_d = den_q; cnt_d = cnt_q; busy_d = busy_q;
    done_d = 1'b0;
    trial = {r_q[8:0], q_q[16]} - {1'b0, den_q};
    if (start_i) begin
      q_d = num_i; r_d = '0; den_d = den_i; cnt_d = 5'd17; busy_d = 1'b1;
    end else if (busy_q) begin
      if ({r_q[8:0], q_q[16]} >= {1'b0, den_q}) begin
        r_d = trial; q_d = {q_q[15:0], 1'b1};
      end else begin
        r_d = {r_q[8:0], q_q[16]}; q_d = {q_q[15:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; den_q <= den_d;
  end
  assign done_o = done_q;
  assign quo_o  = q_q[7:0];
  assign rem_o  = r_q[8:0];
endmodule

// ===== rtl/gie_checker.sv =====
// Port-level checker for the gray image enhance pipeline, bound to the top level.
`include "assert_macros.svh"
module gie_assert (
  input logic clk_i,
  input logic rst_ni,
  input logic vld_i,
  input logic rdy_i,
  input logic stat_i,
  input logic last_i,
  input logic [7:0] pix_i
);
  logic [9:0] res_data;
  assign res_data = {pix_i, last_i, stat_i};

  `ASSERT_NEXT(a_res_hold, clk_i, rst_ni, vld_i && !rdy_i, vld_i, "result dropped")
  `ASSERT_IMPL(a_err, clk_i, rst_ni, vld_i && stat_i, pix_i == '0 && !last_i, "dirty status")
  `ASSERT_NEXT(a_stable, clk_i, rst_ni, vld_i && !rdy_i, $stable(res_data), "payload changed")
endmodule

bind gray_image_enhance_pipeline gie_assert u_gie_assert (
  .clk_i(clk_i), .rst_ni(rst_ni), .vld_i(res_o.valid), .rdy_i(res_o.ready),
  .stat_i(res_o.status), .last_i(res_o.last_out), .pix_i(res_o.pixel_out)
);
